/* hw/rtl/lzss_flagword_decompressor_unit_defines.svh */
// Assertion macros used by the decompressor top-level RTL file.
// No dependencies.
`ifndef LZSS_FLAGWORD_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZSS_FLAGWORD_DECOMPRESSOR_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LZFD_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication checked in the cycle after the condition.
`define LZFD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

/* hw/rtl/lzfd_pkg.sv */
// Package for the LZSS decompressor: constants, types and status codes.
// No dependencies.
package lzfd_pkg;
   localparam int HistoryDepthDefault = 4096;
   localparam int LanesDefault = 4;
   localparam int CountWidth = 21;
   localparam logic [20:0] OutLimitReset = 21'd1048576;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_END    = 2'd1,
      ST_LIMIT  = 2'd2,
      ST_OFFSET = 2'd3
   } status_type;

   localparam logic CSR_ADDR_OUT_LIMIT = 1'b0;
   localparam logic FUNC_DATA = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;
endpackage

/* hw/rtl/lzfd_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lzfd_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/lzss_flagword_decompressor_unit.sv */
// Top level of the LZSS decompressor: token parser, copy engine and output packer.
// Depends on lzfd_pkg, lzfd_ram and the defines header.
//
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    func, in_byte
// rsp       out        rsp_valid/ready    byte_0..3, count, last, status
// csr       in         APB psel/penable   out_limit at address 0
//
// The low byte of a flag word is taken in S_IDLE alone; any other item then passes
// through the flush state that sends its last result. A copy reads history in S_READ
// and writes back the registered RAM read data in S_WRITE for each output byte, then
// makes a final check before the flush. Results of up to four bytes leave through
// one output register; a full register stalls the copy loop and the flush. Reset is
// synchronous and clears control state; the history memory is not cleared.
`include "lzss_flagword_decompressor_unit_defines.svh"
module lzss_flagword_decompressor_unit
   import lzfd_pkg::*;
#(
   parameter int HISTORY_DEPTH = HistoryDepthDefault,
   parameter int LANES = LanesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_0,
   output logic [7:0]  rsp_byte_1,
   output logic [7:0]  rsp_byte_2,
   output logic [7:0]  rsp_byte_3,
   output logic [2:0]  rsp_count,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int PACK = (LANES < 4) ? LANES : 4;
   localparam int PW = $clog2(PACK + 1);

   typedef enum logic [3:0] {
      PH_BIT1, PH_BIT2, PH_S3, PH_S4, PH_SOFF, PH_LIT, PH_LLO, PH_LHI, PH_LEXT
   } phase_type;
   typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE, S_FLUSH} fsm_type;

   logic [20:0] out_limit_ff;
   logic [15:0] flag_bits_ff;
   logic [4:0]  flag_left_ff;
   phase_type   phase_ff;
   logic [7:0]  held_byte_ff;
   logic [3:0]  held_high_ff;
   logic [20:0] written_ff;
   status_type  run_ff;
   fsm_type     fsm_ff;
   logic [8:0]  copy_left_ff;
   logic [12:0] dist_ff;
   status_type  pend_st_ff;
   logic [7:0]  pk_ff [4];
   logic [2:0]  pk_cnt_ff;
   logic [7:0]  ob_ff [4];
   logic [2:0]  ob_cnt_ff;
   logic        ob_last_ff;
   status_type  ob_st_ff;
   logic        ob_valid_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   lzfd_ram #(.Width(8), .Depth(HISTORY_DEPTH)) u_hist (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = {11'd0, out_limit_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= OutLimitReset;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[1:0] == {CSR_ADDR_OUT_LIMIT, 1'b0}) begin
         out_limit_ff <= csr_pwdata[20:0];
      end
   end

   // Output register.
   assign rsp_valid  = ob_valid_ff;
   assign rsp_byte_0 = ob_ff[0];
   assign rsp_byte_1 = ob_ff[1];
   assign rsp_byte_2 = ob_ff[2];
   assign rsp_byte_3 = ob_ff[3];
   assign rsp_count  = ob_cnt_ff;
   assign rsp_last   = ob_last_ff;
   assign rsp_status = ob_st_ff;
   logic ob_free;
   assign ob_free = !ob_valid_ff || rsp_ready;

   assign req_ready = (fsm_ff == S_IDLE);
   logic accept;
   assign accept = req_valid && req_ready;

   // Byte being appended this cycle (literal or copied byte).
   logic [AW-1:0] wpos;
   assign wpos = written_ff[AW-1:0];
   logic [20:0] src_full;
   assign src_full = written_ff - {8'd0, dist_ff};
   assign rd_addr = src_full[AW-1:0];

   // Packer may take a byte when not full or when it can be flushed this cycle.
   logic ob_free_pk;
   assign ob_free_pk = (pk_cnt_ff != PACK[2:0]) || ob_free;

   // Literal: only state that drives a write on accept.
   logic lit_take;
   assign lit_take = accept && req_func == FUNC_DATA && run_ff == ST_OK &&
                     flag_left_ff != 5'd0 && flag_left_ff < 5'd17 && phase_ff == PH_LIT &&
                     written_ff < out_limit_ff;
   assign wr_en   = lit_take || (fsm_ff == S_WRITE && ob_free_pk);
   assign wr_addr = wpos;
   assign wr_data = (fsm_ff == S_WRITE) ? rd_data : req_in_byte;

   // Flag bit decode after an item, run for up to 4 bits in one step.
   logic [15:0] fb_in;
   logic [4:0]  fl_in;
   phase_type   ph_in;
   logic [7:0]  hb_in;
   always_comb begin
      logic b;
      fb_in = flag_bits_ff; fl_in = flag_left_ff; ph_in = phase_ff; hb_in = held_byte_ff;
      for (int i = 0; i < 4; i++) begin
         if (fl_in >= 5'd1 && fl_in <= 5'd16 && ph_in <= PH_S4) begin
            b = fb_in[0];
            fb_in = fb_in >> 1;
            fl_in = fl_in - 5'd1;
            case (ph_in)
               PH_BIT1: ph_in = b ? PH_LIT : PH_BIT2;
               PH_BIT2: ph_in = b ? PH_LLO : PH_S3;
               PH_S3: begin hb_in = {6'd0, b, 1'b0}; ph_in = PH_S4; end
               default: begin hb_in = hb_in + {7'd0, b} + 8'd3; ph_in = PH_SOFF; end
            endcase
         end
      end
   end

   // Main sequencer.
   always_ff @(posedge clock) begin
      logic [7:0] b;
      logic       fin;
      status_type fst;
      logic [2:0] pc;
      logic       ov;
      b = req_in_byte;
      fin = 1'b0;
      fst = ST_OK;
      pc = pk_cnt_ff;
      ov = 1'b0;
      if (reset) begin
         flag_bits_ff <= '0; flag_left_ff <= '0; phase_ff <= PH_BIT1;
         held_byte_ff <= '0; held_high_ff <= '0; written_ff <= '0; run_ff <= ST_OK;
         fsm_ff <= S_IDLE; pk_cnt_ff <= '0; ob_valid_ff <= 1'b0;
         copy_left_ff <= '0; dist_ff <= '0; pend_st_ff <= ST_OK;
      end else begin
         // A waiting result stays until the receiver takes it.
         ov = ob_valid_ff && !rsp_ready;
         case (fsm_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_func == FUNC_RESTART) begin
                     flag_bits_ff <= '0; flag_left_ff <= '0; phase_ff <= PH_BIT1;
                     held_byte_ff <= '0; held_high_ff <= '0; written_ff <= '0;
                     run_ff <= ST_OK;
                  end else if (run_ff != ST_OK) begin
                     // Stopped image: data ignored.
                  end else if (flag_left_ff == 5'd0) begin
                     flag_bits_ff <= {8'd0, b}; flag_left_ff <= 5'd17;
                  end else if (flag_left_ff >= 5'd17) begin
                     flag_bits_ff <= {b, flag_bits_ff[7:0]}; flag_left_ff <= 5'd16;
                     fsm_ff <= S_FLUSH; pend_st_ff <= ST_OK;
                  end else begin
                     fsm_ff <= S_FLUSH; pend_st_ff <= ST_OK;
                     case (phase_ff)
                        PH_LIT: begin
                           phase_ff <= PH_BIT1;
                           if (written_ff >= out_limit_ff) pend_st_ff <= ST_LIMIT;
                           else begin
                              written_ff <= written_ff + 21'd1;
                              pk_ff[pc[1:0]] <= b; pk_cnt_ff <= pc + 3'd1;
                           end
                        end
                        PH_SOFF: begin
                           phase_ff <= PH_BIT1;
                           dist_ff <= 13'h100 - {5'd0, b};
                           copy_left_ff <= {1'b0, held_byte_ff};
                           fsm_ff <= S_READ;
                        end
                        PH_LLO: begin held_byte_ff <= b; phase_ff <= PH_LHI; end
                        PH_LHI: begin
                           if (b[3:0] != 4'd0) begin
                              dist_ff <= 13'h1000 - {1'b0, b[7:4], held_byte_ff};
                              copy_left_ff <= {5'd0, b[3:0]} + 9'd3;
                              phase_ff <= PH_BIT1; fsm_ff <= S_READ;
                           end else begin
                              held_high_ff <= b[7:4]; phase_ff <= PH_LEXT;
                           end
                        end
                        PH_LEXT: begin
                           phase_ff <= PH_BIT1;
                           if (b == 8'd0) pend_st_ff <= ST_END;
                           else begin
                              dist_ff <= 13'h1000 - {1'b0, held_high_ff, held_byte_ff};
                              copy_left_ff <= {1'b0, b} + 9'd1;
                              fsm_ff <= S_READ;
                           end
                        end
                        default: phase_ff <= PH_BIT1;
                     endcase
                  end
               end
            end
            S_READ: begin
               // Checks before each copied byte; the read is issued now.
               if (copy_left_ff == 9'd0) fsm_ff <= S_FLUSH;
               else if (written_ff >= out_limit_ff) begin
                  pend_st_ff <= ST_LIMIT; fsm_ff <= S_FLUSH; copy_left_ff <= '0;
               end else if (written_ff < {8'd0, dist_ff}) begin
                  pend_st_ff <= ST_OFFSET; fsm_ff <= S_FLUSH; copy_left_ff <= '0;
               end else fsm_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (ob_free_pk) begin
                  if (pc == PACK[2:0]) begin
                     ob_ff <= pk_ff; ob_cnt_ff <= pc; ob_last_ff <= 1'b0;
                     ob_st_ff <= ST_OK; ov = 1'b1; pc = 3'd0;
                  end
                  pk_ff[pc[1:0]] <= rd_data; pk_cnt_ff <= pc + 3'd1;
                  written_ff <= written_ff + 21'd1;
                  copy_left_ff <= copy_left_ff - 9'd1;
                  fsm_ff <= S_READ;
               end
            end
            default: begin
               // Finish the item: emit the last packed result or status, if there is one.
               fst = pend_st_ff;
               if (pc == 3'd0 && fst == ST_OK) begin
                  fsm_ff <= S_IDLE;
                  fin = 1'b1;
               end else if (ob_free) begin
                  for (int j = 0; j < 4; j++) begin
                     ob_ff[j] <= (j < int'(pc)) ? pk_ff[j] : 8'd0;
                  end
                  ob_cnt_ff <= pc; ob_last_ff <= 1'b1;
                  ob_st_ff <= fst; ov = 1'b1; pk_cnt_ff <= '0;
                  fsm_ff <= S_IDLE;
                  fin = 1'b1;
               end
               // The stop status or the next flag bits take effect as the item ends.
               if (fin) begin
                  if (fst != ST_OK) run_ff <= fst;
                  else begin
                     flag_bits_ff <= fb_in; flag_left_ff <= fl_in;
                     phase_ff <= ph_in; held_byte_ff <= hb_in;
                  end
               end
            end
         endcase
         ob_valid_ff <= ov;
      end
   end

   `LZFD_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, fsm_ff == S_IDLE)
   `LZFD_ASSERT_IMP(a_pack_bound, clock, reset, 1'b1, pk_cnt_ff <= PACK[2:0])
   `LZFD_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_count))
endmodule
